[hw/rtl/plti_pkg.sv]
// package for the piecewise linear table interpolator
// table depth, field widths, request layout, command and register codes
// no dependencies
`timescale 1ns / 1ps

package plti_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int IDX_W   = 8;
	localparam int WL_W    = 16;
	localparam int COEF_W  = 24;
	localparam int ECNT_W  = 9;
	localparam int SCALE_W = 16;
	localparam int PROD_W  = WL_W + COEF_W;
	localparam int ENTRY_W = WL_W + COEF_W;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 24;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_SCALE  = 1'b1;

	localparam logic [SCALE_W-1:0] COEF_SCALE_RST = 16'd256;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	typedef struct packed {
		logic [COEF_W-1:0] coef_value;
		logic [WL_W-1:0]   wavelength;
		logic [IDX_W-1:0]  entry_index;
	} in_data_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] num;
		logic [WL_W-1:0]   den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quot;
	} div_rsp_t;

	function automatic logic [CNT_W-1:0] clamp_count(input logic [ECNT_W-1:0] c);
		if (int'(c) > TABLE_DEPTH)
			return CNT_W'(TABLE_DEPTH);
		else
			return CNT_W'(c);
	endfunction

endpackage

[hw/rtl/plti_ram.sv]
// generic single write port, single read port ram
// registered read data; no dependencies
`timescale 1ns / 1ps

module plti_ram #(
	parameter int DW = 40,
	parameter int AW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/plti_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
// depends on plti_pkg
`timescale 1ns / 1ps

module plti_div (
	input  logic                clk,
	input  logic                arst_n,
	input  plti_pkg::div_req_t  req,
	output plti_pkg::div_rsp_t  rsp
);
	import plti_pkg::*;

	localparam int STEP_W = $clog2(PROD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [PROD_W-1:0] num_q;
	logic [WL_W-1:0]   den_q;
	logic [WL_W-1:0]   rem_q;
	logic [WL_W:0]     trial;
	logic [WL_W:0]     diff;
	logic              qbit;

	assign trial = {rem_q, num_q[PROD_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign qbit  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[PROD_W-2:0], qbit};
			rem_q <= qbit ? diff[WL_W-1:0] : trial[WL_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = num_q;

endmodule

[hw/rtl/plti_ctrl.sv]
// sequencer: config registers, table scan over the ram, interpolation and gain
// depends on plti_pkg; drives plti_ram and plti_div ports
`timescale 1ns / 1ps

module plti_ctrl (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [plti_pkg::IN_DATA_W-1:0]        s_axis_tdata,
	input  logic                                  s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [plti_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	output logic                                  m_axis_tuser,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [plti_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [plti_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                  ram_we,
	output logic [plti_pkg::ADDR_W-1:0]           ram_waddr,
	output logic [plti_pkg::ENTRY_W-1:0]          ram_wdata,
	output logic [plti_pkg::ADDR_W-1:0]           ram_raddr,
	input  logic [plti_pkg::ENTRY_W-1:0]          ram_rdata,
	output plti_pkg::div_req_t                    div_req,
	input  plti_pkg::div_rsp_t                    div_rsp
);
	import plti_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RD0   = 4'd1;
	localparam logic [3:0] ST_SCAN  = 4'd2;
	localparam logic [3:0] ST_MULD  = 4'd3;
	localparam logic [3:0] ST_DIVGO = 4'd4;
	localparam logic [3:0] ST_DIVW  = 4'd5;
	localparam logic [3:0] ST_MUL   = 4'd6;
	localparam logic [3:0] ST_SAT   = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	logic [3:0]         state_q;
	logic [ECNT_W-1:0]  entry_count_q;
	logic [SCALE_W-1:0] coef_scale_q;
	logic [CNT_W-1:0]   n_q;
	logic [ADDR_W-1:0]  i_q;
	logic [WL_W-1:0]    query_q;
	logic [WL_W-1:0]    prev_wl_q;
	logic [COEF_W-1:0]  prev_coef_q;
	logic [WL_W-1:0]    dx_q;
	logic [WL_W-1:0]    span_q;
	logic [COEF_W-1:0]  dy_q;
	logic               up_q;
	logic [PROD_W-1:0]  prod_q;
	logic [COEF_W-1:0]  interp_q;
	logic [COEF_W-1:0]  res_value_q;
	logic               res_status_q;
	logic               out_valid_q;
	logic [COEF_W-1:0]  out_value_q;
	logic               out_status_q;

	in_data_t           in_d;
	logic               in_acc;
	logic [WL_W-1:0]    rd_wl;
	logic [COEF_W-1:0]  rd_coef;
	logic [PROD_W-1:0]  dxdy;
	logic [PROD_W-1:0]  scaled;
	logic               out_free;
	logic               is_last;

	assign in_d     = in_data_t'(s_axis_tdata);
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign rd_wl    = ram_rdata[WL_W-1:0];
	assign rd_coef  = ram_rdata[ENTRY_W-1:WL_W];
	assign dxdy     = dx_q * dy_q;
	assign scaled   = interp_q * coef_scale_q;
	assign out_free = !out_valid_q || m_axis_tready;
	assign is_last  = ((CNT_W'(i_q) + CNT_W'(1)) == n_q);

	// only idle takes requests, so a table write never overlaps a scan read
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;

	assign ram_we    = in_acc && (s_axis_tuser == CMD_WRITE) &&
	                   (int'(in_d.entry_index) < TABLE_DEPTH);
	assign ram_waddr = ADDR_W'(in_d.entry_index);
	assign ram_wdata = {in_d.coef_value, in_d.wavelength};
	assign ram_raddr = (state_q == ST_IDLE) ? '0 : (i_q + ADDR_W'(1));

	assign div_req.start = (state_q == ST_DIVGO);
	assign div_req.num   = prod_q;
	assign div_req.den   = span_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			coef_scale_q  <= COEF_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ENTRY_COUNT: entry_count_q <= cfg_data[ECNT_W-1:0];
				REG_COEF_SCALE:  coef_scale_q  <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_axis_tuser == CMD_WRITE)
							state_q <= ST_DONE;
						else if (clamp_count(entry_count_q) == '0)
							state_q <= ST_DONE;
						else
							state_q <= ST_RD0;
					end
				end
				ST_RD0: begin
					if (rd_wl >= query_q || n_q == CNT_W'(1))
						state_q <= ST_MUL;
					else
						state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (rd_wl >= query_q)
						state_q <= ST_MULD;
					else if (is_last)
						state_q <= ST_MUL;
				end
				ST_MULD:  state_q <= ST_DIVGO;
				ST_DIVGO: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (div_rsp.done)
						state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_SAT;
				ST_SAT: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				query_q      <= in_d.wavelength;
				n_q          <= clamp_count(entry_count_q);
				i_q          <= '0;
				res_value_q  <= '0;
				res_status_q <= (s_axis_tuser == CMD_LOOKUP &&
				                 clamp_count(entry_count_q) == '0) ? STATUS_EMPTY : STATUS_OK;
			end
			ST_RD0: begin
				interp_q    <= rd_coef;
				prev_wl_q   <= rd_wl;
				prev_coef_q <= rd_coef;
				i_q         <= ADDR_W'(1);
			end
			ST_SCAN: begin
				interp_q    <= rd_coef;
				i_q         <= i_q + ADDR_W'(1);
				dx_q        <= query_q - prev_wl_q;
				span_q      <= rd_wl - prev_wl_q;
				up_q        <= (rd_coef >= prev_coef_q);
				dy_q        <= (rd_coef >= prev_coef_q) ? (rd_coef - prev_coef_q)
				                                        : (prev_coef_q - rd_coef);
				// keep the lower point for the interpolation
				if (rd_wl < query_q) begin
					prev_wl_q   <= rd_wl;
					prev_coef_q <= rd_coef;
				end
			end
			ST_MULD: prod_q <= dxdy;
			ST_DIVW: begin
				if (up_q)
					interp_q <= prev_coef_q + div_rsp.quot[COEF_W-1:0];
				else
					interp_q <= prev_coef_q - div_rsp.quot[COEF_W-1:0];
			end
			ST_MUL: prod_q <= scaled;
			ST_SAT: begin
				res_value_q <= (|prod_q[PROD_W-1:COEF_W+8]) ? '1 : prod_q[COEF_W+7:8];
			end
			ST_DONE: begin
				if (out_free) begin
					out_value_q  <= res_value_q;
					out_status_q <= res_status_q;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_value_q;
	assign m_axis_tuser  = out_status_q;

endmodule

[hw/rtl/piecewise_linear_table_interp_top.sv]
// a write goes from idle to the done state and then to the output register; a lookup
// scans the table ram one point per cycle until a point at or above the query or the last
// active point, runs the bit-serial divider when that point closes a segment, then applies the gain
// one request at a time; a new request is taken while the previous result waits in the output register
// reset clears control and config (entry_count 0, coef_scale 256); table contents
// are undefined until written and get no clearing pass
`timescale 1ns / 1ps

module piecewise_linear_table_interp_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// entry_index [7:0], wavelength [23:8], coef_value [47:24]
	input  logic [plti_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// cmd
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// value [23:0]
	output logic [plti_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// status
	output logic                             m_axis_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [plti_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [plti_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import plti_pkg::*;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0]  ram_wdata;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [ENTRY_W-1:0]  ram_rdata;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	plti_ram #(
		.DW (ENTRY_W),
		.AW (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	plti_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	plti_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata),
		.div_req       (div_req),
		.div_rsp       (div_rsp)
	);

endmodule

[hw/rtl/plti_chk.sv]
// port-level checker for the interpolator top, bound to it below
// depends on plti_pkg and piecewise_linear_table_interp_top
`timescale 1ns / 1ps

module plti_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [plti_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input logic                             s_axis_tuser,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [plti_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input logic                             m_axis_tuser,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic [plti_pkg::CFG_IDX_W-1:0]   cfg_index,
	input logic [plti_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import plti_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// empty-table status always carries a zero value
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == STATUS_EMPTY |-> m_axis_tdata == '0)
		else $error("empty status with nonzero value");

	// one request in flight: ready drops right after a request is taken
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while busy");

	// no result can appear before a request has passed the state register and the output valid register
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("result too early");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind piecewise_linear_table_interp_top plti_chk u_plti_chk (.*);

[test/plti_lookup_checker.sv]
// checker for the piecewise linear table interpolator: mirrors the config registers
// and the point table, predicts every result and compares it in order
// depends on plti_pkg
`timescale 1ns / 1ps

module plti_lookup_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [plti_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                            s_axis_tuser,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [plti_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                            m_axis_tuser,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [plti_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [plti_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              open_results,
	output int                              mismatches
);
	import plti_pkg::*;

	typedef struct packed {
		logic [OUT_DATA_W-1:0] value;
		logic                  status;
	} lookup_result_t;

	logic [WL_W-1:0]    point_wl   [TABLE_DEPTH];
	logic [COEF_W-1:0]  point_coef [TABLE_DEPTH];
	logic [ECNT_W-1:0]  num_entries;
	logic [SCALE_W-1:0] gain;
	lookup_result_t     awaited [$];
	in_data_t           req;
	lookup_result_t     got;
	lookup_result_t     want;

	function automatic lookup_result_t predict_lookup(input logic [WL_W-1:0] q);
		lookup_result_t r;
		int unsigned n;
		longint unsigned x0, x1, y0, y1, dx, span, interp, prod;
		r.value  = '0;
		r.status = STATUS_OK;
		n = (int'(num_entries) > TABLE_DEPTH) ? TABLE_DEPTH : int'(num_entries);
		if (n == 0) begin
			r.status = STATUS_EMPTY;
			return r;
		end
		if (point_wl[0] >= q) begin
			interp = point_coef[0];
		end else begin
			interp = point_coef[n-1];
			for (int i = 1; i < n; i++) begin
				if (point_wl[i] >= q) begin
					x0 = point_wl[i-1];
					x1 = point_wl[i];
					y0 = point_coef[i-1];
					y1 = point_coef[i];
					span = x1 - x0;
					dx = longint'(q) - x0;
					if (span == 0)
						interp = y0;
					else if (y1 >= y0)
						interp = y0 + (dx * (y1 - y0)) / span;
					else
						interp = y0 - (dx * (y0 - y1)) / span;
					break;
				end
			end
		end
		prod = (interp * longint'(gain)) >> 8;
		r.value = (prod > 64'hFF_FFFF) ? 24'hFF_FFFF : prod[OUT_DATA_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited.delete();
			num_entries  = '0;
			gain         = COEF_SCALE_RST;
			open_results = 0;
			mismatches   = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ENTRY_COUNT)
					num_entries = cfg_data[ECNT_W-1:0];
				else if (cfg_index == REG_COEF_SCALE)
					gain = cfg_data[SCALE_W-1:0];
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.value  = m_axis_tdata;
				got.status = m_axis_tuser;
				if (awaited.size() == 0) begin
					$error("result with nothing awaited: value %h, status %b",
						got.value, got.status);
					mismatches++;
				end else begin
					want = awaited.pop_front();
					if (got.value !== want.value) begin
						$error("value mismatch: expected %h, actual %h", want.value, got.value);
						mismatches++;
					end
					if (got.status !== want.status) begin
						$error("status mismatch: expected %b, actual %b",
							want.status, got.status);
						mismatches++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				req = in_data_t'(s_axis_tdata);
				if (s_axis_tuser == CMD_WRITE) begin
					point_wl[req.entry_index]   = req.wavelength;
					point_coef[req.entry_index] = req.coef_value;
					want.value  = '0;
					want.status = STATUS_OK;
				end else begin
					want = predict_lookup(req.wavelength);
				end
				awaited = {awaited, want};
			end
			open_results = awaited.size();
		end
	end

endmodule

[test/tb_top.sv]
// testbench top for piecewise_linear_table_interp_top: directed and random table
// writes and lookups over several gain and count settings, random stalls on both sides
// depends on plti_pkg, the block and plti_lookup_checker
`timescale 1ns / 1ps

module tb_top;

	import plti_pkg::*;

	localparam int ITEM_TARGET = 900;
	localparam int QUIET_LIMIT = 20000;
	localparam int DRAIN_WAIT  = 400;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    open_results;
	int                    mismatches;

	int                    results_seen = 0;
	int                    writes_sent  = 0;
	int                    lookups_sent = 0;
	int                    settings     = 0;
	bit                    gapless      = 0;
	logic [WL_W-1:0]       shadow_wl [TABLE_DEPTH];

	piecewise_linear_table_interp_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	plti_lookup_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.open_results  (open_results),
		.mismatches    (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			results_seen <= results_seen + 1;
	end

	function automatic int sender_gap();
		int r;
		if (gapless)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic int sink_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 3);
		if (r < 90)
			return $urandom_range(4, 12);
		return $urandom_range(20, 100);
	endfunction

	function automatic logic [COEF_W-1:0] random_coef();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 20)
			return '1;
		return COEF_W'($urandom);
	endfunction

	function automatic logic [SCALE_W-1:0] random_scale();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 25)
			return COEF_SCALE_RST;
		if (r < 40)
			return '1;
		if (r < 50)
			return SCALE_W'(1);
		return SCALE_W'($urandom);
	endfunction

	// queries aimed at the active points, with some outside and some fully random
	function automatic logic [WL_W-1:0] pick_query(input int n);
		int unsigned r, s, lo, hi, t;
		if (n == 0)
			return WL_W'($urandom);
		r  = $urandom_range(0, 99);
		s  = $urandom_range(0, n - 1);
		lo = shadow_wl[0];
		hi = shadow_wl[n-1];
		if (lo > hi) begin
			t  = lo;
			lo = hi;
			hi = t;
		end
		if (r < 30)
			return shadow_wl[s];
		if (r < 40)
			return WL_W'(shadow_wl[s] + 1);
		if (r < 75)
			return WL_W'($urandom_range(hi, lo));
		if (r < 83)
			return WL_W'($urandom_range(lo, 0));
		if (r < 90)
			return WL_W'($urandom_range(65535, hi));
		return WL_W'($urandom);
	endfunction

	// leaves tvalid high after the handshake so a back-to-back request needs no toggle
	task automatic send_request(input logic cmd, input logic [IDX_W-1:0] idx,
			input logic [WL_W-1:0] wl, input logic [COEF_W-1:0] coef);
		int gap;
		in_data_t req;
		gap = sender_gap();
		req.entry_index = idx;
		req.wavelength  = wl;
		req.coef_value  = coef;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= req;
		do @(posedge clk); while (!s_axis_tready);
		if (cmd == CMD_WRITE) begin
			writes_sent++;
			shadow_wl[idx] = wl;
		end else begin
			lookups_sent++;
		end
	endtask

	task automatic write_point(input int idx, input int unsigned wl,
			input logic [COEF_W-1:0] coef);
		send_request(CMD_WRITE, IDX_W'(idx), WL_W'(wl), coef);
	endtask

	task automatic lookup(input int unsigned q);
		send_request(CMD_LOOKUP, IDX_W'($urandom), WL_W'(q), COEF_W'($urandom));
	endtask

	// called in the step of the last handshake; waits until every result is back
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (open_results != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_block(input logic [CFG_DATA_W-1:0] count_word,
			input logic [SCALE_W-1:0] scale);
		cfg_valid <= 1'b1;
		cfg_index <= REG_ENTRY_COUNT;
		cfg_data  <= count_word;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_COEF_SCALE;
		cfg_data  <= CFG_DATA_W'(scale);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	task automatic fill_points(input int n, input bit sorted);
		int unsigned wl, step_max;
		wl = $urandom_range(0, 2000);
		step_max = (65535 - wl) / n;
		for (int i = 0; i < n; i++) begin
			if (!sorted)
				wl = $urandom_range(0, 65535);
			else if (i > 0)
				wl = wl + $urandom_range(0, step_max);
			write_point(i, wl, random_coef());
		end
	endtask

	// result side: random stalls, calm stretches, and one long hold-off
	initial begin : result_sink
		int hold;
		bit calm;
		bit long_done;
		hold = 0;
		calm = 0;
		long_done = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 199) == 0)
				calm = !calm;
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!long_done && results_seen >= 200) begin
					hold = 1000;
					long_done = 1;
				end else if (!calm && $urandom_range(0, 99) < 30) begin
					hold = sink_gap();
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		int n_pts, cnt, eff, sel, phase;
		logic [CFG_DATA_W-1:0] count_word;
		logic [SCALE_W-1:0] scale;
		bit sorted;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= CMD_WRITE;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_ENTRY_COUNT;
		cfg_data      <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty table after reset
		lookup(16'h0000);
		lookup(16'hFFFF);
		// rising then falling segment, plus the top slot
		write_point(0, 16'h0100, 24'h00_0000);
		write_point(1, 16'h0200, 24'hFF_FFFF);
		write_point(2, 16'hFFF0, 24'h00_0001);
		write_point(255, 16'hFFFF, 24'hAB_CDEF);
		settle();
		program_block(CFG_DATA_W'(3), COEF_SCALE_RST);
		lookup(16'h0000);
		lookup(16'h0100);
		lookup(16'h0180);
		lookup(16'h0200);
		lookup(16'h8000);
		lookup(16'hFFF0);
		lookup(16'hFFFF);
		write_point(3, 16'h0050, 24'h12_3456);
		settle();
		// saturating gain, then zero gain
		program_block(CFG_DATA_W'(3), 16'hFFFF);
		lookup(16'h0200);
		lookup(16'h0180);
		lookup(16'h0000);
		settle();
		program_block(CFG_DATA_W'(3), 16'h0000);
		lookup(16'h0200);
		lookup(16'h0180);
		settle();

		// random phases; the first one writes every slot so no lookup reads stale memory
		phase = 0;
		while (writes_sent + lookups_sent < ITEM_TARGET) begin
			if (phase == 0)
				n_pts = TABLE_DEPTH;
			else if ($urandom_range(0, 99) < 85)
				n_pts = $urandom_range(1, 16);
			else
				n_pts = $urandom_range(17, TABLE_DEPTH);
			sel = $urandom_range(0, 99);
			if (phase == 0 || sel < 70)
				cnt = n_pts;
			else if (sel < 78)
				cnt = 0;
			else if (sel < 88)
				cnt = $urandom_range(TABLE_DEPTH + 1, 511);
			else
				cnt = $urandom_range(1, TABLE_DEPTH);
			count_word = CFG_DATA_W'(cnt);
			if ($urandom_range(0, 3) == 0)
				count_word[CFG_DATA_W-1:ECNT_W] = (CFG_DATA_W-ECNT_W)'($urandom >> 3);
			scale = (phase == 0) ? COEF_SCALE_RST : random_scale();
			gapless = ($urandom_range(0, 2) == 0);
			sorted = (phase == 0) || ($urandom_range(0, 9) != 0);
			settle();
			program_block(count_word, scale);
			fill_points(n_pts, sorted);
			eff = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
			repeat ($urandom_range(10, 40)) begin
				if ($urandom_range(0, 99) < 85)
					lookup(pick_query(eff));
				else
					write_point($urandom_range(0, TABLE_DEPTH - 1), $urandom_range(0, 65535),
						random_coef());
			end
			phase++;
		end

		settle();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("covered %0d table writes and %0d lookups over %0d count/gain settings",
			writes_sent, lookups_sent, settings);
		$display("%0d results compared, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
